// ===== design/rct_pkg.sv =====
package rct_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int WORD_W     = 64;
	localparam int KEY_WORDS  = 4;
	localparam int TTL_W      = 16;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(400);

	// register indexes
	localparam logic REG_TTL = 1'b0;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_addr;
		logic busy;
		logic hit;
	} dp_stat_t;

endpackage

// ===== design/rct_if.sv =====
interface rct_claim_if;
	logic                              valid;
	logic                              ready;
	logic        [rct_pkg::WORD_W-1:0] key_word0;
	logic        [rct_pkg::WORD_W-1:0] key_word1;
	logic        [rct_pkg::WORD_W-1:0] key_word2;
	logic        [rct_pkg::WORD_W-1:0] key_word3;
	logic signed [rct_pkg::WORD_W-1:0] now_secs;

	modport source (output valid, key_word0, key_word1, key_word2, key_word3, now_secs,
		input ready);
	modport sink (input valid, key_word0, key_word1, key_word2, key_word3, now_secs,
		output ready);
endinterface

interface rct_verdict_if;
	logic valid;
	logic ready;
	logic accepted;

	modport source (output valid, accepted, input ready);
	modport sink (input valid, accepted, output ready);
endinterface

// ===== design/rct_datapath.sv =====
module rct_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rct_pkg::dp_cmd_t                  cmd,
	output rct_pkg::dp_stat_t                 stat,
	input  rct_pkg::key_t                     in_key,
	input  logic signed [rct_pkg::WORD_W-1:0] in_now,
	input  logic        [rct_pkg::TTL_W-1:0]  ttl
);
	import rct_pkg::*;

	localparam int ENTRY_W = (KEY_WORDS + 1) * WORD_W;

	// ring storage: key words in the low part, stamp on top
	logic [ENTRY_W-1:0] mem [RING_DEPTH];

	key_t                     key_q;
	logic signed [WORD_W-1:0] now_q;
	logic [SLOT_W-1:0]        scan_addr_q;
	logic [SLOT_W-1:0]        write_slot_q;
	logic [FILL_W-1:0]        fill_q;
	logic                     hit_q;

	logic [ENTRY_W-1:0] rdata_s1;
	logic               vld_s1;
	logic               wr_s1;
	logic               vld_s2;
	logic               key_eq_s2;
	logic               live_s2;

	key_t                     rd_key;
	logic signed [WORD_W-1:0] rd_stamp;
	logic        [WORD_W-1:0] age;
	logic                     key_eq;
	logic                     live;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= in_key;
			now_q <= in_now;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_s1 <= mem[scan_addr_q];
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_q) begin
			mem[write_slot_q] <= {now_q, key_q};
		end
	end

	// slots never written read as zero key with zero stamp
	always_comb begin
		rd_key   = wr_s1 ? key_t'(rdata_s1[KEY_WORDS*WORD_W-1:0]) : '0;
		rd_stamp = wr_s1 ? $signed(rdata_s1[ENTRY_W-1:KEY_WORDS*WORD_W]) : '0;
		key_eq   = (rd_key == key_q);
		age      = now_q - rd_stamp;
		live     = (now_q < rd_stamp) ||
			((age[WORD_W-1:TTL_W] == '0) && (age[TTL_W-1:0] < ttl));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q  <= '0;
			write_slot_q <= '0;
			fill_q       <= '0;
			hit_q        <= 1'b0;
			vld_s1       <= 1'b0;
			wr_s1        <= 1'b0;
			vld_s2       <= 1'b0;
			key_eq_s2    <= 1'b0;
			live_s2      <= 1'b0;
		end else begin
			vld_s1    <= cmd.rd_en;
			wr_s1     <= ({1'b0, scan_addr_q} < fill_q);
			vld_s2    <= vld_s1;
			key_eq_s2 <= key_eq;
			live_s2   <= live;
			if (cmd.capture) begin
				scan_addr_q <= '0;
				hit_q       <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					scan_addr_q <= (scan_addr_q == SLOT_W'(RING_DEPTH - 1)) ? '0
						: scan_addr_q + SLOT_W'(1);
				end
				if (vld_s2 && key_eq_s2 && live_s2) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit && !hit_q) begin
				write_slot_q <= (write_slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0
					: write_slot_q + SLOT_W'(1);
				if (fill_q != FILL_W'(RING_DEPTH)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	assign stat.last_addr = (scan_addr_q == SLOT_W'(RING_DEPTH - 1));
	assign stat.busy      = vld_s1 | vld_s2;
	assign stat.hit       = hit_q;

endmodule

// ===== design/rct_ctrl.sv =====
module rct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_accepted,
	output rct_pkg::dp_cmd_t   cmd,
	input  rct_pkg::dp_stat_t  stat
);
	import rct_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_accepted_q;
	logic   out_free;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign out_accepted = out_accepted_q;
	assign out_free     = !out_valid_q || out_ready;

	always_comb begin
		cmd.capture = in_valid && in_ready;
		cmd.rd_en   = (state_q == ST_SCAN);
		cmd.commit  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			out_accepted_q <= 1'b0;
		end else begin
			// a verdict taken while the next one is posted is replaced in ST_DONE
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.last_addr) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_accepted_q <= !stat.hit;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/replay_cache_with_ttl.sv =====
// channel   dir  handshake       payload
// claim     in   valid/ready     key_word0..key_word3, now_secs
// verdict   out  valid/ready     accepted
// apb       in   psel/penable    paddr, pwdata, prdata (ttl_secs at 0x0)
//
// from accept to verdict the ring is
// read one slot a cycle through the single read port of the ring memory
// slots not yet written since reset read as zero key with zero stamp
// (tracked by a fill count, so no clearing pass after reset)
// the verdict sits in an output register; the next item is taken while it waits
// a finished scan holds in its last state while the previous verdict is not taken
module replay_cache_with_ttl (
	input  logic                         clk,
	input  logic                         arst_n,
	rct_claim_if.sink                    claim,
	rct_verdict_if.source                verdict,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rct_pkg::PADDR_W-1:0]  paddr,
	input  logic [rct_pkg::PDATA_W-1:0]  pwdata,
	output logic [rct_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import rct_pkg::*;

	// ttl register
	logic [TTL_W-1:0] ttl_q;
	logic             reg_sel;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	key_t     in_key;

	// word-aligned register index lives in paddr[2]
	assign reg_sel = (paddr[2] == REG_TTL);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(PDATA_W - TTL_W){1'b0}}, ttl_q} : '0;

	// writes off the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			ttl_q <= pwdata[TTL_W-1:0];
		end
	end

	// key words packed low word first
	assign in_key = {claim.key_word3, claim.key_word2, claim.key_word1, claim.key_word0};

	// sequencer: accept, scan the ring, drain the read pipe, commit and report
	rct_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (claim.valid),
		.in_ready     (claim.ready),
		.out_valid    (verdict.valid),
		.out_ready    (verdict.ready),
		.out_accepted (verdict.accepted),
		.cmd          (cmd),
		.stat         (stat)
	);

	// ring memory, compare and liveness check, write pointer
	rct_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.in_key (in_key),
		.in_now (claim.now_secs),
		.ttl    (ttl_q)
	);

endmodule

// ===== verif/claim_check_pkg.sv =====
package claim_check_pkg;

	import rct_pkg::*;

	// mirror of the replay ring plus the queue of verdicts still owed by the block
	class verdict_book;
		logic [TTL_W-1:0]         ttl;
		key_t                     ring_key [RING_DEPTH];
		logic signed [WORD_W-1:0] ring_stamp [RING_DEPTH];
		int unsigned              next_slot;
		bit                       owed_accept [$];
		int unsigned              failures;

		function new();
			ttl       = TTL_RESET;
			next_slot = 0;
			failures  = 0;
			foreach (ring_key[i]) begin
				ring_key[i]   = '0;
				ring_stamp[i] = '0;
			end
		endfunction

		// unmapped indexes are dropped, only the low ttl bits are kept
		function void write_reg(int unsigned idx, logic [PDATA_W-1:0] value);
			if (idx == int'(REG_TTL)) begin
				ttl = value[TTL_W-1:0];
			end
		endfunction

		// exact signed age, one bit wider than the stamps so it never wraps
		function bit still_blocking(logic signed [WORD_W-1:0] now, logic signed [WORD_W-1:0] stamp);
			logic signed [WORD_W:0] age;
			age = $signed({now[WORD_W-1], now}) - $signed({stamp[WORD_W-1], stamp});
			return age < $signed({{(WORD_W + 1 - TTL_W){1'b0}}, ttl});
		endfunction

		function void note_claim(key_t key, logic signed [WORD_W-1:0] now);
			bit replay;
			replay = 1'b0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				if (ring_key[i] == key && still_blocking(now, ring_stamp[i])) begin
					replay = 1'b1;
					break;
				end
			end
			if (!replay) begin
				ring_key[next_slot]   = key;
				ring_stamp[next_slot] = now;
				next_slot             = (next_slot + 1) % RING_DEPTH;
			end
			owed_accept.push_back(!replay);
		endfunction

		function void check_verdict(logic got);
			bit want;
			if (owed_accept.size() == 0) begin
				$error("accepted: expected nothing, got %0b", got);
				failures++;
				return;
			end
			want = owed_accept.pop_front();
			if (got !== want) begin
				$error("accepted: expected %0b, got %0b", want, got);
				failures++;
			end
		endfunction

		function int outstanding();
			return owed_accept.size();
		endfunction
	endclass

endpackage

// ===== verif/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rct_pkg::*;
	import claim_check_pkg::*;

	// each item scans the full ring
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int HIST_DEPTH  = 32;
	localparam int PHASE_ITEMS = 29;

	// byte addresses: the ttl register and the first unmapped slot after it
	localparam logic [PADDR_W-1:0] TTL_ADDR   = PADDR_W'(int'(REG_TTL)) << 2;
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(int'(REG_TTL) + 1) << 2;

	localparam logic signed [WORD_W-1:0] MAX_NOW = {1'b0, {(WORD_W - 1){1'b1}}};
	localparam logic signed [WORD_W-1:0] MIN_NOW = {1'b1, {(WORD_W - 1){1'b0}}};

	typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

	typedef struct {
		key_t                     key;
		logic signed [WORD_W-1:0] now;
	} claim_rec_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	rct_claim_if   claim_ch ();
	rct_verdict_if verdict_ch ();

	verdict_book              book;
	int unsigned              src_idle_pct;
	int unsigned              sink_stall_pct;
	claim_rec_t               history [$];
	logic signed [WORD_W-1:0] clock_now;
	int                       cycle_count;

	replay_cache_with_ttl DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.claim   (claim_ch),
		.verdict (verdict_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver side: random back-pressure, re-rolled every cycle
	always @(negedge clk) begin
		verdict_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// verdicts are checked before the claim of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (verdict_ch.valid && verdict_ch.ready) begin
				book.check_verdict(verdict_ch.accepted);
			end
			if (claim_ch.valid && claim_ch.ready) begin
				book.note_claim({claim_ch.key_word3, claim_ch.key_word2,
					claim_ch.key_word1, claim_ch.key_word0}, claim_ch.now_secs);
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic void set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			IDLE_SOURCE: begin
				src_idle_pct   = 63;
				sink_stall_pct = 0;
			end
			IDLE_SINK: begin
				src_idle_pct   = 0;
				sink_stall_pct = 63;
			end
			default: begin
				src_idle_pct   = 34;
				sink_stall_pct = 34;
			end
		endcase
	endfunction

	function automatic key_t rand_key();
		key_t key;
		for (int w = 0; w < KEY_WORDS; w++) begin
			key[w] = {$urandom, $urandom};
		end
		return key;
	endfunction

	// one claim item; returns just after the falling edge that follows acceptance
	task automatic send_claim(key_t key, logic signed [WORD_W-1:0] now);
		while ($urandom_range(99) < src_idle_pct) begin
			claim_ch.valid <= 1'b0;
			@(negedge clk);
		end
		claim_ch.valid     <= 1'b1;
		claim_ch.key_word0 <= key[0];
		claim_ch.key_word1 <= key[1];
		claim_ch.key_word2 <= key[2];
		claim_ch.key_word3 <= key[3];
		claim_ch.now_secs  <= now;
		do @(posedge clk); while (!claim_ch.ready);
		history.push_back('{key: key, now: now});
		if (history.size() > HIST_DEPTH) begin
			void'(history.pop_front());
		end
		@(negedge clk);
	endtask

	// drop valid and let every owed verdict come back before touching the register
	task automatic drain();
		claim_ch.valid <= 1'b0;
		while (book.outstanding() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// setup cycle then access cycle
	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.write_reg(addr >> 2, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// replays of recent keys around the ttl boundary, plus near misses, fresh keys and noise
	task automatic random_claim();
		int unsigned              pick;
		int unsigned              span;
		longint                   offset;
		claim_rec_t               old;
		key_t                     key;
		logic signed [WORD_W-1:0] now;
		pick = $urandom_range(99);
		span = book.ttl;
		if (history.size() != 0) begin
			old = history[$urandom_range(history.size() - 1)];
		end
		if (pick < 40 && history.size() != 0) begin
			// same key again, just inside, on, or past expiry, or earlier in time
			case ($urandom_range(4))
				0: offset = longint'(span) - 1;
				1: offset = longint'(span);
				2: offset = longint'(span) + 1;
				3: offset = longint'($urandom_range(span * 2));
				default: offset = -longint'($urandom_range(span + 1));
			endcase
			key = old.key;
			now = old.now + offset;
		end else if (pick < 48 && history.size() != 0) begin
			// near miss: one key bit off
			key = old.key;
			key[$urandom_range(KEY_WORDS - 1)][$urandom_range(WORD_W - 1)] ^= 1'b1;
			now = old.now;
		end else if (pick < 58) begin
			// zero key near time zero hits the empty slots
			key = '0;
			now = $urandom_range(span * 2);
		end else if (pick < 68) begin
			key = rand_key();
			now = {$urandom, $urandom};
		end else begin
			key       = rand_key();
			clock_now = clock_now + $urandom_range(span * 2 + 2);
			now       = clock_now;
		end
		send_claim(key, now);
	endtask

	initial begin
		key_t             ones_miss;
		key_t             key_a;
		key_t             key_b;
		key_t             key_c;
		key_t             key_d;
		key_t             key_e;
		logic [TTL_W-1:0] phase_ttl [4];
		idle_mode_t       phase_mode [4];

		// everything known from time zero
		book               = new();
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		claim_ch.valid     = 1'b0;
		claim_ch.key_word0 = '0;
		claim_ch.key_word1 = '0;
		claim_ch.key_word2 = '0;
		claim_ch.key_word3 = '0;
		claim_ch.now_secs  = '0;
		verdict_ch.ready   = 1'b0;
		clock_now          = 64'sd1_700_000_000;
		set_idle(IDLE_NONE);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		key_a        = rand_key();
		key_b        = rand_key();
		key_c        = rand_key();
		key_d        = rand_key();
		key_e        = rand_key();
		ones_miss    = '1;
		ones_miss[3] = '0;

		// reset ttl: empty slots are zero key, stamp zero, live below the ttl
		send_claim('0, 64'sd0);
		send_claim('0, 64'sd399);
		send_claim('0, 64'sd400);
		// expiry edge and time going backwards
		send_claim('1, 64'sd1000);
		send_claim('1, 64'sd1399);
		send_claim('1, 64'sd1400);
		send_claim('1, 64'sd1000);
		send_claim(ones_miss, 64'sd1000);
		// extremes of time: a negative age is live, a huge gap must not wrap
		send_claim(key_a, MAX_NOW);
		send_claim(key_a, MIN_NOW);
		send_claim(key_b, MIN_NOW);
		send_claim(key_b, MAX_NOW);
		drain();

		// smallest nonzero ttl
		write_reg(TTL_ADDR, PDATA_W'(1));
		send_claim(key_c, 64'sd5);
		send_claim(key_c, 64'sd5);
		send_claim(key_c, 64'sd6);
		drain();

		// zero ttl: only a negative age still blocks
		write_reg(TTL_ADDR, '0);
		send_claim(key_c, 64'sd6);
		send_claim(key_c, 64'sd5);
		drain();

		// largest ttl
		write_reg(TTL_ADDR, PDATA_W'(65535));
		send_claim(key_d, 64'sd100);
		send_claim(key_d, 64'sd100 + 64'sd65534);
		send_claim(key_d, 64'sd100 + 64'sd65535);
		drain();

		// upper data bits dropped, unmapped address ignored, ttl ends at 2
		write_reg(TTL_ADDR, 32'hDEAD_0002);
		write_reg(SPARE_ADDR, PDATA_W'(7));
		send_claim(key_e, 64'sd10);
		send_claim(key_e, 64'sd11);
		send_claim(key_e, 64'sd12);
		drain();

		// random part: one ttl and one idling pattern per phase
		phase_ttl[0]  = TTL_RESET;
		phase_ttl[1]  = 16'd1;
		phase_ttl[2]  = 16'd65535;
		phase_ttl[3]  = TTL_W'($urandom_range(65535, 1));
		phase_mode[0] = IDLE_NONE;
		phase_mode[1] = IDLE_SOURCE;
		phase_mode[2] = IDLE_SINK;
		phase_mode[3] = IDLE_BOTH;
		for (int p = 0; p < 4; p++) begin
			write_reg(TTL_ADDR, PDATA_W'(phase_ttl[p]));
			set_idle(phase_mode[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_claim();
			end
			drain();
		end

		// quiet tail long enough for a stray verdict to show up
		repeat (RING_DEPTH + 16) @(negedge clk);
		if (book.failures == 0 && book.outstanding() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/rct_pkg.sv
design/rct_if.sv
design/rct_datapath.sv
design/rct_ctrl.sv
design/replay_cache_with_ttl.sv
verif/claim_check_pkg.sv
verif/testbench.sv
